### hdl/swk_pkg.sv
// Shared types and constants for the swerve wheel kinematics unit.
// Command and result item structs, CORDIC cell record, arctangent table.
// No dependencies.
package swk_pkg;

	// CORDIC depth, clipped to the size of the arctangent table
	localparam int CORDIC_STAGES = 16;
	localparam int MAX_STAGES    = 24;
	localparam int NUM_CELLS     = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
	localparam int STAGE_W       = 5;

	// spacing of accepted items; one wheel enters the chain per cycle
	localparam int ITEM_CYCLES = 4;
	// accept edge to result edge: front end, cells, back end, wheel issue, output register
	localparam int LATENCY = NUM_CELLS + 9;

	localparam logic [14:0] COS45_Q15    = 15'd23170;
	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
	localparam logic [31:0] ANGLE_PI     = 32'h8000_0000;

	// config register indexes
	localparam logic REG_WHEEL_DISTANCE = 1'b0;
	localparam logic REG_INV_RADIUS     = 1'b1;

	localparam logic [15:0] WHEEL_DISTANCE_RST = 16'd4634;
	localparam logic [15:0] INV_RADIUS_RST     = 16'd5120;

	// wheel indexes
	localparam logic [1:0] WHEEL_FL = 2'd0;
	localparam logic [1:0] WHEEL_RL = 2'd1;
	localparam logic [1:0] WHEEL_RR = 2'd2;
	localparam logic [1:0] WHEEL_FR = 2'd3;

	typedef struct packed {
		logic signed [15:0] linear_x;
		logic signed [15:0] linear_y;
		logic signed [15:0] angular_z;
	} swk_cmd_t;

	typedef struct packed {
		logic signed [15:0] steer_front_left;
		logic signed [15:0] steer_rear_left;
		logic signed [15:0] steer_rear_right;
		logic signed [15:0] steer_front_right;
		logic [15:0]        speed_front_left;
		logic [15:0]        speed_rear_left;
		logic [15:0]        speed_rear_right;
		logic [15:0]        speed_front_right;
	} swk_result_t;

	// one wheel vector in flight through the CORDIC chain
	typedef struct packed {
		logic               valid;
		logic               zero;
		logic [1:0]         wheel;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [31:0]        z;
	} swk_cell_t;

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic [31:0] atan_angle(input logic [STAGE_W-1:0] i);
		logic [31:0] a;
		case (i)
			5'd0:    a = 32'h20000000;
			5'd1:    a = 32'h12E4051E;
			5'd2:    a = 32'h09FB385B;
			5'd3:    a = 32'h051111D4;
			5'd4:    a = 32'h028B0D43;
			5'd5:    a = 32'h0145D7E1;
			5'd6:    a = 32'h00A2F61E;
			5'd7:    a = 32'h00517C55;
			5'd8:    a = 32'h0028BE53;
			5'd9:    a = 32'h00145F2F;
			5'd10:   a = 32'h000A2F98;
			5'd11:   a = 32'h000517CC;
			5'd12:   a = 32'h00028BE6;
			5'd13:   a = 32'h000145F3;
			5'd14:   a = 32'h0000A2FA;
			5'd15:   a = 32'h0000517D;
			5'd16:   a = 32'h000028BE;
			5'd17:   a = 32'h0000145F;
			5'd18:   a = 32'h00000A30;
			5'd19:   a = 32'h00000518;
			5'd20:   a = 32'h0000028C;
			5'd21:   a = 32'h00000146;
			5'd22:   a = 32'h000000A3;
			5'd23:   a = 32'h00000051;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

endpackage

### hdl/swk_front.sv
// Front end: command accept, turn offset r = wz * d*cos45, wheel issue and
// pre-rotation into the CORDIC chain. Depends on swk_pkg.
module swk_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  swk_pkg::swk_cmd_t   cmd,
	input  logic [15:0]         wheel_distance,
	output swk_pkg::swk_cell_t  vec_out
);
	import swk_pkg::*;

	logic [1:0]         busy_cnt_q;
	logic               accept;
	logic [16:0]        a_q;
	logic [30:0]        a_prod;
	logic [31:0]        a_sum;
	logic               v_s1;
	swk_cmd_t           cmd_s1;
	logic signed [33:0] r_prod;
	logic signed [33:0] r_sum;
	logic signed [15:0] vx_s2;
	logic signed [15:0] vy_s2;
	logic signed [17:0] r_s2;
	logic               issue_q;
	logic [1:0]         wsel_q;
	logic signed [18:0] wx;
	logic signed [18:0] wy;
	logic signed [31:0] px;
	logic signed [31:0] py;
	swk_cell_t          pre_s3;

	assign accept = start & ~busy;
	assign busy   = (busy_cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= 2'd0;
		end else if (accept) begin
			busy_cnt_q <= 2'(ITEM_CYCLES - 1);
		end else if (busy) begin
			busy_cnt_q <= busy_cnt_q - 2'd1;
		end
	end

	// d*cos45, follows the register; the user must change config only while idle, the block does not enforce it
	assign a_prod = 31'(wheel_distance) * 31'(COS45_Q15);
	assign a_sum  = 32'(a_prod) + 32'h0000_4000;

	always_ff @(posedge clk) begin
		a_q <= a_sum[31:15];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
	end

	assign r_prod = 34'(cmd_s1.angular_z) * 34'(signed'({1'b0, a_q}));
	assign r_sum  = r_prod + 34'sd8192;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			vx_s2 <= cmd_s1.linear_x;
			vy_s2 <= cmd_s1.linear_y;
			r_s2  <= r_sum[31:14];
		end
	end

	// wheel sequencer: one wheel per cycle, FL, RL, RR, FR in turn
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			wsel_q  <= WHEEL_FL;
		end else if (v_s1) begin
			issue_q <= 1'b1;
			wsel_q  <= WHEEL_FL;
		end else if (issue_q) begin
			wsel_q <= wsel_q + 2'd1;
			if (wsel_q == WHEEL_FR) begin
				issue_q <= 1'b0;
			end
		end
	end

	// left wheels see -r on x, front-left and front-right see +r on y
	always_comb begin
		if (wsel_q == WHEEL_FL || wsel_q == WHEEL_RL) begin
			wx = 19'(vx_s2) - 19'(r_s2);
		end else begin
			wx = 19'(vx_s2) + 19'(r_s2);
		end
		if (wsel_q == WHEEL_FL || wsel_q == WHEEL_FR) begin
			wy = 19'(vy_s2) + 19'(r_s2);
		end else begin
			wy = 19'(vy_s2) - 19'(r_s2);
		end
		px = 32'(wx) <<< 12;
		py = 32'(wy) <<< 12;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_s3 <= '0;
		end else begin
			pre_s3.valid <= issue_q;
			pre_s3.zero  <= (wx == 19'sd0) && (wy == 19'sd0);
			pre_s3.wheel <= wsel_q;
			if (px < 0) begin
				pre_s3.x <= -px;
				pre_s3.y <= -py;
				pre_s3.z <= ANGLE_PI;
			end else begin
				pre_s3.x <= px;
				pre_s3.y <= py;
				pre_s3.z <= 32'h0;
			end
		end
	end

	assign vec_out = pre_s3;

endmodule

### hdl/swk_cordic_cell.sv
// One CORDIC vectoring micro-rotation with its output register.
// Depends on swk_pkg.
module swk_cordic_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [swk_pkg::STAGE_W-1:0] stage,
	input  swk_pkg::swk_cell_t          vec_in,
	output swk_pkg::swk_cell_t          vec_out
);
	import swk_pkg::*;

	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic [31:0]        ang;
	swk_cell_t          rot_q;

	assign dx  = vec_in.y >>> stage;
	assign dy  = vec_in.x >>> stage;
	assign ang = atan_angle(stage);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= '0;
		end else begin
			rot_q.valid <= vec_in.valid;
			rot_q.zero  <= vec_in.zero;
			rot_q.wheel <= vec_in.wheel;
			if (vec_in.y >= 0) begin
				rot_q.x <= vec_in.x + dx;
				rot_q.y <= vec_in.y - dy;
				rot_q.z <= vec_in.z + ang;
			end else begin
				rot_q.x <= vec_in.x - dx;
				rot_q.y <= vec_in.y + dy;
				rot_q.z <= vec_in.z - ang;
			end
		end
	end

	assign vec_out = rot_q;

endmodule

### hdl/swk_back.sv
// Back end: angle rounding, gain removal, speed scaling with saturation,
// and collection of four wheels into one result item. Depends on swk_pkg.
module swk_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swk_pkg::swk_cell_t   vec_in,
	input  logic [15:0]          inverse_wheel_radius,
	output logic                 done,
	output swk_pkg::swk_result_t result
);
	import swk_pkg::*;

	logic [31:0]        z_rnd;
	logic [31:0]        xc;
	logic [63:0]        m_prod;
	logic               v_s4;
	logic               zero_s4;
	logic [1:0]         wheel_s4;
	logic signed [15:0] angle_s4;
	logic [31:0]        m_s4;
	logic [47:0]        s_prod;
	logic [23:0]        s_full;
	logic               v_s5;
	logic [1:0]         wheel_s5;
	logic signed [15:0] angle_s5;
	logic [15:0]        speed_s5;
	logic signed [15:0] steer_fl_q, steer_rl_q, steer_rr_q;
	logic [15:0]        speed_fl_q, speed_rl_q, speed_rr_q;
	logic               done_q;
	swk_result_t        result_q;

	assign z_rnd  = vec_in.z + 32'h0000_8000;
	assign xc     = (vec_in.x < 0) ? 32'h0 : 32'(vec_in.x);
	assign m_prod = 64'(xc) * 64'(INV_GAIN_Q32) + 64'h0000_0000_8000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= vec_in.valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		zero_s4  <= vec_in.zero;
		wheel_s4 <= vec_in.wheel;
		angle_s4 <= vec_in.zero ? 16'sd0 : signed'(z_rnd[31:16]);
		m_s4     <= m_prod[63:32];
	end

	assign s_prod = 48'(m_s4) * 48'(inverse_wheel_radius) + 48'h00_0000_80_0000;
	assign s_full = s_prod[47:24];

	always_ff @(posedge clk) begin
		wheel_s5 <= wheel_s4;
		angle_s5 <= angle_s4;
		if (zero_s4) begin
			speed_s5 <= 16'd0;
		end else if (s_full[23:16] != 8'd0) begin
			speed_s5 <= 16'hFFFF;
		end else begin
			speed_s5 <= s_full[15:0];
		end
	end

	// hold wheels 0..2, release the item when the last wheel lands
	always_ff @(posedge clk) begin
		if (v_s5) begin
			case (wheel_s5)
				WHEEL_FL: begin
					steer_fl_q <= angle_s5;
					speed_fl_q <= speed_s5;
				end
				WHEEL_RL: begin
					steer_rl_q <= angle_s5;
					speed_rl_q <= speed_s5;
				end
				WHEEL_RR: begin
					steer_rr_q <= angle_s5;
					speed_rr_q <= speed_s5;
				end
				default: begin
					result_q.steer_front_left  <= steer_fl_q;
					result_q.steer_rear_left   <= steer_rl_q;
					result_q.steer_rear_right  <= steer_rr_q;
					result_q.steer_front_right <= angle_s5;
					result_q.speed_front_left  <= speed_fl_q;
					result_q.speed_rear_left   <= speed_rl_q;
					result_q.speed_rear_right  <= speed_rr_q;
					result_q.speed_front_right <= speed_s5;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s5 && (wheel_s5 == WHEEL_FR);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### hdl/swerve_wheel_kinematics_unit.sv
// Top level of the four-wheel swerve inverse kinematics unit.
// Depends on swk_pkg, swk_front, swk_cordic_cell, swk_back.
//
// Usage:
//   Command channel: drive cmd (linear_x, linear_y, angular_z, signed Q4.12)
//   and raise start; the item is taken at a clock edge where start is high
//   and busy is low. busy then stays high while the front end counts out the
//   item spacing, so a new command can be taken as soon as it falls, back to back.
//   Result channel: done pulses for exactly one cycle with the four steering
//   angles (binary angle, 32768 = pi) and four wheel spin rates (Q8.8,
//   saturating) on result. There is no backpressure: the receiver must take
//   the item in that cycle.
//   Path: each command passes the front end, the CORDIC cells and the back end
//   on its way from the accept edge to the edge that takes the result.
//   Chain: the four wheel vectors of an item share one pipelined CORDIC
//   chain, entering it one wheel per cycle; sharing that chain sets the command rate.
//   Results leave in command order.
//   Config: APB-style port, wheel_distance at 0x0, inverse_wheel_radius at
//   0x4, both 16 bits. Write only while idle.
//   Reset: arst_n clears all control and valid state and loads the register
//   defaults (distance 4634, inverse radius 5120); no items are in flight.
module swerve_wheel_kinematics_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  swk_pkg::swk_cmd_t    cmd,
	output logic                 done,
	output swk_pkg::swk_result_t result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import swk_pkg::*;

	logic [15:0] wheel_distance_q;
	logic [15:0] inv_radius_q;
	logic        cfg_wr;

	// cell chain taps: entry 0 is the pre-rotated vector from the front end
	swk_cell_t   chain [NUM_CELLS+1];

	// ---------------- config registers ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_distance_q <= WHEEL_DISTANCE_RST;
			inv_radius_q     <= INV_RADIUS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WHEEL_DISTANCE: wheel_distance_q <= pwdata[15:0];
				REG_INV_RADIUS:     inv_radius_q     <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WHEEL_DISTANCE: prdata = 32'(wheel_distance_q);
			REG_INV_RADIUS:     prdata = 32'(inv_radius_q);
		endcase
	end

	// ---------------- datapath ----------------
	// front end: accept, turn offset, per-wheel vectors, half-plane fold
	swk_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.wheel_distance (wheel_distance_q),
		.vec_out        (chain[0])
	);

	// CORDIC vectoring chain, one micro-rotation per cell
	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cordic
		swk_cordic_cell u_rot (
			.clk     (clk),
			.arst_n  (arst_n),
			.stage   (STAGE_W'(g)),
			.vec_in  (chain[g]),
			.vec_out (chain[g+1])
		);
	end

	// back end: magnitude, speed, gather four wheels into one item
	swk_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.vec_in               (chain[NUM_CELLS]),
		.inverse_wheel_radius (inv_radius_q),
		.done                 (done),
		.result               (result)
	);

`ifndef SYNTHESIS
	// an accepted command blocks the next one for the following cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// every accepted command yields its result after the fixed latency
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(LATENCY) done)
		else $error("result missing at expected latency");

	// done drops again right after each result strobe
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");
`endif

endmodule
